/* rtl/grc_pkg.sv */
package grc_pkg;

    localparam int MAP_SIDE   = 64;
    localparam int MAP_BITS   = 6;
    localparam int ADDR_BITS  = 2 * MAP_BITS;
    localparam int FRAC_BITS  = 10;
    localparam int QSH        = 30;
    localparam int ANG_BITS   = 12;
    localparam int POS_BITS   = 16;
    localparam int DIST_BITS  = 17;
    localparam int WALK_STEPS = 2 * MAP_SIDE + 4;
    localparam int CORDIC_N   = 30;

    localparam logic [DIST_BITS-1:0] MAX_DIST_RESET = 17'd20480;
    localparam logic signed [33:0]   CORDIC_K       = 34'sd652032874;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [MAP_BITS-1:0] cell_col;
        logic [MAP_BITS-1:0] cell_row;
        logic                cell_solid;
        logic [POS_BITS-1:0] pos_x;
        logic [POS_BITS-1:0] pos_y;
        logic [ANG_BITS-1:0] azimuth;
    } t_word;

    typedef struct packed {
        logic  valid;
        t_word word;
    } t_fb;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bf;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/grc_front.sv */
module grc_front import grc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic [MAP_BITS-1:0] i_cell_col,
    input  logic [MAP_BITS-1:0] i_cell_row,
    input  logic                i_cell_solid,
    input  logic [POS_BITS-1:0] i_pos_x,
    input  logic [POS_BITS-1:0] i_pos_y,
    input  logic [ANG_BITS-1:0] i_azimuth,
    output t_fb                 o_fb,
    input  t_bf                 i_bf
);

    t_word      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_word      w_in;

    assign o_ready = (r_cnt != 2'd2) && !i_bf.clearing;
    assign push    = i_valid && o_ready;
    assign pop     = i_bf.pop && (r_cnt != 2'd0);

    always_comb begin
        w_in.kind       = (i_kind == KIND_CAST) ? KIND_CAST : KIND_WRITE;
        w_in.cell_col   = i_cell_col;
        w_in.cell_row   = i_cell_row;
        w_in.cell_solid = i_cell_solid;
        w_in.pos_x      = i_pos_x;
        w_in.pos_y      = i_pos_y;
        w_in.azimuth    = i_azimuth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= w_in;
    end

    assign o_fb.valid = (r_cnt != 2'd0);
    assign o_fb.word  = r_q[r_rp];

endmodule

/* rtl/grc_back.sv */
module grc_back import grc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_fb                  i_fb,
    output t_bf                  o_bf,
    input  logic [DIST_BITS-1:0] i_max_dist,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic                 o_side,
    output logic [MAP_BITS-1:0]  o_hit_col,
    output logic [MAP_BITS-1:0]  o_hit_row,
    output logic [DIST_BITS-1:0] o_distance
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CORD  = 4'd2;
    localparam logic [3:0] S_QUAD  = 4'd3;
    localparam logic [3:0] S_MM    = 4'd4;
    localparam logic [3:0] S_HSET  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_OFF   = 4'd7;
    localparam logic [3:0] S_WA    = 4'd8;
    localparam logic [3:0] S_WB    = 4'd9;
    localparam logic [3:0] S_WC    = 4'd10;
    localparam logic [3:0] S_SQRT  = 4'd11;
    localparam logic [3:0] S_NEXT  = 4'd12;
    localparam logic [3:0] S_RES   = 4'd13;

    logic [3:0]           r_st;
    logic [ADDR_BITS-1:0] r_clr;

    logic                 r_map [MAP_SIDE*MAP_SIDE];
    logic                 r_rd;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic                 mem_wdata;
    logic [ADDR_BITS-1:0] mem_raddr;

    logic [POS_BITS-1:0]  r_px, r_py;
    logic [1:0]           r_quad;
    logic signed [33:0]   r_x, r_y, r_cos, r_sin;
    logic signed [32:0]   r_z;
    logic [4:0]           r_i;

    logic [31:0]          mul_a, mul_b;
    logic [63:0]          r_prod, r_sq;
    logic [33:0]          r_mm;

    logic                 r_half;
    logic [61:0]          r_dsh, r_quo;
    logic [31:0]          r_dvs, r_rem;
    logic [5:0]           r_dcnt;
    logic                 r_dneg;

    logic [63:0]          r_acc;
    logic [FRAC_BITS-1:0] r_offm;
    logic [3:0]           r_ocnt;
    logic                 r_oneg;

    logic signed [63:0]   r_slope, r_m, r_base;
    logic signed [11:0]   r_line;
    logic [POS_BITS-1:0]  r_maj0;
    logic                 r_dir;
    logic [7:0]           r_k;
    logic                 r_oob;

    logic [63:0]          r_sv, r_res;
    logic [4:0]           r_scnt;
    logic [MAP_BITS-1:0]  r_wc, r_wr;

    logic                 r_hok, r_vok;
    logic [DIST_BITS-1:0] r_hd, r_vd;
    logic [MAP_BITS-1:0]  r_hc, r_hr, r_vc, r_vr;

    logic                 r_ovalid, r_ohit, r_oside;
    logic [MAP_BITS-1:0]  r_ocol, r_orow;
    logic [DIST_BITS-1:0] r_odist;

    logic signed [33:0]   xs, ys;
    logic signed [33:0]   num, den, anum, aden;
    logic [POS_BITS-1:0]  maj0, min0;
    logic                 dir;
    logic [16:0]          maj_up;
    logic [6:0]           line0;
    logic [32:0]          dt;
    logic                 dge;
    logic [63:0]          n_acc, prodq;
    logic signed [23:0]   lval, dmaj_s, dmaj_a;
    logic signed [63:0]   dd, ad;
    logic [63:0]          dsh20;
    logic [31:0]          dmin;
    logic signed [11:0]   cm;
    logic [MAP_BITS-1:0]  cn, wcol, wrow;
    logic                 oob;
    logic [63:0]          sum;
    logic [63:0]          bitv, trial;
    logic                 out_free;
    logic                 hwin;

    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;

    always_comb begin
        if (!r_half) begin
            num  = r_cos;
            den  = r_sin;
            maj0 = r_py;
            min0 = r_px;
        end else begin
            num  = r_sin;
            den  = r_cos;
            maj0 = r_px;
            min0 = r_py;
        end
        dir   = (den > 0);
        anum  = (num < 0) ? -num : num;
        aden  = (den < 0) ? -den : den;
        maj_up = {1'b0, maj0} + 17'd1023;
        line0 = dir ? maj_up[16:10] : {1'b0, maj0[15:10]};
    end

    assign dt  = {r_rem, r_dsh[61]};
    assign dge = dt >= {1'b0, r_dvs};

    assign n_acc = r_acc + (r_offm[r_ocnt] ? ({2'b0, r_quo} << r_ocnt) : 64'd0);
    assign prodq = n_acc >> FRAC_BITS;

    always_comb begin
        lval   = $signed({{2{r_line[11]}}, r_line, 10'b0});
        dmaj_s = lval - $signed({8'b0, r_maj0});
        dmaj_a = (dmaj_s < 0) ? -dmaj_s : dmaj_s;
        dd     = r_m - r_base;
        ad     = (dd < 0) ? -dd : dd;
        dsh20  = ad >> 20;
        dmin   = (dsh20 > 64'h8000_0000) ? 32'h8000_0000 : dsh20[31:0];
        cm     = r_dir ? r_line : r_line - 12'sd1;
        cn     = r_m[35:30];
        oob    = (cm < 0) || (cm >= 12'sd64) || (r_m < 0) || (r_m[63:36] != '0);
        wcol   = r_half ? cm[5:0] : cn;
        wrow   = r_half ? cn : cm[5:0];
    end

    assign mem_raddr = {wrow, wcol};
    assign sum       = r_sq + r_prod;
    assign bitv      = 64'd1 << (6'd62 - {r_scnt, 1'b0});
    assign trial     = r_res + bitv;
    assign out_free  = !r_ovalid || i_ready;
    assign hwin      = r_hok && (!r_vok || (r_hd <= r_vd));

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (r_st)
            S_QUAD: begin
                mul_a = {15'b0, i_max_dist};
                mul_b = {15'b0, i_max_dist};
            end
            S_WA: begin
                mul_a = {8'b0, dmaj_a[23:0]};
                mul_b = {8'b0, dmaj_a[23:0]};
            end
            S_WB: begin
                mul_a = dmin;
                mul_b = dmin;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = 1'b0;
        if (r_st == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_st == S_IDLE && i_fb.valid && i_fb.word.kind == KIND_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = {i_fb.word.cell_row, i_fb.word.cell_col};
            mem_wdata = i_fb.word.cell_solid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_map[mem_waddr] <= mem_wdata;
        r_rd <= r_map[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_fb.valid && i_fb.word.kind == KIND_CAST) begin
                        r_st <= (i_fb.word.azimuth[9:0] == '0) ? S_QUAD : S_CORD;
                    end
                end
                S_CORD: if (r_i == 5'(CORDIC_N - 1)) r_st <= S_QUAD;
                S_QUAD: r_st <= S_MM;
                S_MM:   r_st <= S_HSET;
                S_HSET: r_st <= (den == 0) ? S_NEXT : S_DIV;
                S_DIV:  if (r_dcnt == 6'd61) r_st <= S_OFF;
                S_OFF:  if (r_ocnt == 4'(FRAC_BITS - 1)) r_st <= S_WA;
                S_WA:   r_st <= S_WB;
                S_WB:   r_st <= S_WC;
                S_WC: begin
                    if (sum >= {30'b0, r_mm} || r_oob) r_st <= S_NEXT;
                    else if (r_rd) r_st <= S_SQRT;
                    else if (r_k == 8'(WALK_STEPS - 1)) r_st <= S_NEXT;
                    else r_st <= S_WA;
                end
                S_SQRT: if (r_scnt == 5'd31) r_st <= S_NEXT;
                S_NEXT: r_st <= r_half ? S_RES : S_HSET;
                S_RES: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_st     <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_st)
            S_IDLE: begin
                r_px   <= i_fb.word.pos_x;
                r_py   <= i_fb.word.pos_y;
                r_quad <= i_fb.word.azimuth[11:10];
                r_i    <= '0;
                r_z    <= $signed({3'b0, i_fb.word.azimuth[9:0], 20'b0});
                r_hok  <= 1'b0;
                r_vok  <= 1'b0;
                r_half <= 1'b0;
                if (i_fb.word.azimuth[9:0] == '0) begin
                    r_x <= 34'sd1 <<< QSH;
                    r_y <= '0;
                end else begin
                    r_x <= CORDIC_K;
                    r_y <= '0;
                end
            end
            S_CORD: begin
                r_i <= r_i + 1'b1;
                if (r_z >= 0) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - $signed({1'b0, atan_turn(r_i)});
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + $signed({1'b0, atan_turn(r_i)});
                end
            end
            S_QUAD: begin
                unique case (r_quad)
                    2'd0: begin r_cos <= r_x;  r_sin <= r_y;  end
                    2'd1: begin r_cos <= -r_y; r_sin <= r_x;  end
                    2'd2: begin r_cos <= -r_x; r_sin <= -r_y; end
                    2'd3: begin r_cos <= r_y;  r_sin <= -r_x; end
                    default: begin r_cos <= r_x; r_sin <= r_y; end
                endcase
            end
            S_MM: r_mm <= r_prod[33:0];
            S_HSET: begin
                r_dsh  <= {anum[31:0], 30'b0};
                r_dvs  <= aden[31:0];
                r_rem  <= '0;
                r_quo  <= '0;
                r_dcnt <= '0;
                r_dneg <= (num < 0) ^ (den < 0);
                r_maj0 <= maj0;
                r_base <= $signed({28'b0, min0, 20'b0});
                r_dir  <= dir;
                r_line <= $signed({5'b0, line0});
                r_offm <= dir ? (-maj0[9:0]) : maj0[9:0];
                r_oneg <= !dir;
                r_acc  <= '0;
                r_ocnt <= '0;
            end
            S_DIV: begin
                r_rem  <= dge ? 32'(dt - {1'b0, r_dvs}) : dt[31:0];
                r_quo  <= {r_quo[60:0], dge};
                r_dsh  <= {r_dsh[60:0], 1'b0};
                r_dcnt <= r_dcnt + 1'b1;
            end
            S_OFF: begin
                r_acc  <= n_acc;
                r_ocnt <= r_ocnt + 1'b1;
                if (r_ocnt == 4'(FRAC_BITS - 1)) begin
                    r_slope <= r_dneg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});
                    r_m     <= r_base + ((r_oneg ^ r_dneg) ? -$signed(prodq) : $signed(prodq));
                    r_k     <= '0;
                end
            end
            S_WA: r_oob <= oob;
            S_WB: r_sq  <= r_prod;
            S_WC: begin
                r_sv   <= sum;
                r_res  <= '0;
                r_scnt <= '0;
                r_wc   <= wcol;
                r_wr   <= wrow;
                r_line <= r_dir ? r_line + 12'sd1 : r_line - 12'sd1;
                r_m    <= r_dir ? r_m + r_slope : r_m - r_slope;
                r_k    <= r_k + 1'b1;
            end
            S_SQRT: begin
                r_scnt <= r_scnt + 1'b1;
                if (r_sv >= trial) begin
                    r_sv  <= r_sv - trial;
                    r_res <= (r_res >> 1) + bitv;
                end else begin
                    r_res <= r_res >> 1;
                end
                if (r_scnt == 5'd31) begin
                    if (!r_half) begin
                        r_hok <= 1'b1;
                        r_hd  <= (r_sv >= trial) ? DIST_BITS'((r_res >> 1) + bitv)
                                                 : DIST_BITS'(r_res >> 1);
                        r_hc  <= r_wc;
                        r_hr  <= r_wr;
                    end else begin
                        r_vok <= 1'b1;
                        r_vd  <= (r_sv >= trial) ? DIST_BITS'((r_res >> 1) + bitv)
                                                 : DIST_BITS'(r_res >> 1);
                        r_vc  <= r_wc;
                        r_vr  <= r_wr;
                    end
                end
            end
            S_NEXT: r_half <= 1'b1;
            S_RES: begin
                if (out_free) begin
                    priority if (hwin) begin
                        r_ohit  <= 1'b1;
                        r_oside <= 1'b0;
                        r_ocol  <= r_hc;
                        r_orow  <= r_hr;
                        r_odist <= r_hd;
                    end else if (r_vok) begin
                        r_ohit  <= 1'b1;
                        r_oside <= 1'b1;
                        r_ocol  <= r_vc;
                        r_orow  <= r_vr;
                        r_odist <= r_vd;
                    end else begin
                        r_ohit  <= 1'b0;
                        r_oside <= 1'b0;
                        r_ocol  <= '0;
                        r_orow  <= '0;
                        r_odist <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_bf.pop      = (r_st == S_IDLE) && i_fb.valid;
    assign o_bf.clearing = (r_st == S_CLEAR);

    assign o_valid    = r_ovalid;
    assign o_hit      = r_ohit;
    assign o_side     = r_oside;
    assign o_hit_col  = r_ocol;
    assign o_hit_row  = r_orow;
    assign o_distance = r_odist;

endmodule

/* rtl/grid_ray_wall_caster_core.sv */
// Map write: applied in the back end once at the queue head; no result.
// Cast: a CORDIC rotation (skipped at quarter turns), then per half a bit-serial divide, a
// walk over at most 132 grid crossings through the shared multiplier and, on a hit, the
// 32-step root; a half whose ray runs parallel to its grid lines is skipped.
// Reset (synchronous, active low) clears control state, sets max_distance to 20480 and
// starts a pass that clears all 4096 map cells while no word is accepted.
module grid_ray_wall_caster_core import grc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [MAP_BITS-1:0]  i_cell_col,
    input  logic [MAP_BITS-1:0]  i_cell_row,
    input  logic                 i_cell_solid,
    input  logic [POS_BITS-1:0]  i_pos_x,
    input  logic [POS_BITS-1:0]  i_pos_y,
    input  logic [ANG_BITS-1:0]  i_azimuth,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic                 o_side,
    output logic [MAP_BITS-1:0]  o_hit_col,
    output logic [MAP_BITS-1:0]  o_hit_row,
    output logic [DIST_BITS-1:0] o_distance
);

    logic [DIST_BITS-1:0] r_max_dist;
    t_fb                  fb;
    t_bf                  bf;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {15'b0, r_max_dist};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAX_DIST_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_max_dist <= pwdata[DIST_BITS-1:0];
        end
    end

    grc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_cell_col   (i_cell_col),
        .i_cell_row   (i_cell_row),
        .i_cell_solid (i_cell_solid),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_azimuth    (i_azimuth),
        .o_fb         (fb),
        .i_bf         (bf)
    );

    grc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fb       (fb),
        .o_bf       (bf),
        .i_max_dist (r_max_dist),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_hit      (o_hit),
        .o_side     (o_side),
        .o_hit_col  (o_hit_col),
        .o_hit_row  (o_hit_row),
        .o_distance (o_distance)
    );

endmodule

/* rtl/grc_checker.sv */
module grc_checker import grc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [2:0]           paddr,
    input logic [31:0]          pwdata,
    input logic [31:0]          prdata,
    input logic                 pready,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 i_kind,
    input logic [MAP_BITS-1:0]  i_cell_col,
    input logic [MAP_BITS-1:0]  i_cell_row,
    input logic                 i_cell_solid,
    input logic [POS_BITS-1:0]  i_pos_x,
    input logic [POS_BITS-1:0]  i_pos_y,
    input logic [ANG_BITS-1:0]  i_azimuth,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic                 o_hit,
    input logic                 o_side,
    input logic [MAP_BITS-1:0]  o_hit_col,
    input logic [MAP_BITS-1:0]  o_hit_row,
    input logic [DIST_BITS-1:0] o_distance
);

    a_reset_blocks_input: assert property (@(posedge i_clk) !i_rst_n |=> !o_ready)
        else $error("input accepted right after reset");

    a_reset_no_result: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (!o_side && o_hit_col == '0 && o_hit_row == '0
                                 && o_distance == '0))
        else $error("miss result carries non-zero fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_distance) && $stable(o_hit)))
        else $error("stalled result changed");

endmodule

bind grid_ray_wall_caster_core grc_checker u_grc_checker (.*);

/* verif/grid_ray_wall_caster_checker.sv */
module grid_ray_wall_caster_checker import grc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    input  logic                 i_valid,
    input  logic                 i_ready_in,
    input  logic                 i_kind,
    input  logic [MAP_BITS-1:0]  i_cell_col,
    input  logic [MAP_BITS-1:0]  i_cell_row,
    input  logic                 i_cell_solid,
    input  logic [POS_BITS-1:0]  i_pos_x,
    input  logic [POS_BITS-1:0]  i_pos_y,
    input  logic [ANG_BITS-1:0]  i_azimuth,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_hit,
    input  logic                 i_side,
    input  logic [MAP_BITS-1:0]  i_hit_col,
    input  logic [MAP_BITS-1:0]  i_hit_row,
    input  logic [DIST_BITS-1:0] i_distance,
    output int                   o_fails,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_MAX_DIST = 3'd0;

    typedef struct packed {
        logic                 hit;
        logic                 side;
        logic [MAP_BITS-1:0]  col;
        logic [MAP_BITS-1:0]  row;
        logic [DIST_BITS-1:0] len;
    } t_wall_hit;

    localparam longint ARC_TURN [CORDIC_N] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
    };

    logic                 solid_map [MAP_SIDE*MAP_SIDE];
    logic [DIST_BITS-1:0] range_limit;
    t_wall_hit            hits_due [$];
    int                   fails;
    int                   due_cnt;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void ray_dir(input logic [ANG_BITS-1:0] az,
                                    output longint cx, output longint sy);
        longint x, y, z, t, xs, ys;
        logic [1:0] quad;
        quad = az[11:10];
        z = longint'(az[9:0]) << 20;
        x = CORDIC_K;
        y = 0;
        if (z == 0) begin
            x = 64'sd1 << QSH;
        end else begin
            for (int i = 0; i < CORDIC_N; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= ARC_TURN[i];
                end else begin
                    x += ys; y -= xs; z += ARC_TURN[i];
                end
            end
        end
        case (quad)
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        cx = x;
        sy = y;
    endfunction

    function automatic logic trace_half(longint maj0, longint min0, longint slope, int dir,
                                        logic vert, output longint unsigned hit_len,
                                        output int col, output int row);
        longint one, up, line, m, base, dmaj, dmin, cm, cn;
        longint unsigned d;
        one  = 64'sd1 << FRAC_BITS;
        up   = 64'sd1 << (QSH - FRAC_BITS);
        line = dir > 0 ? (maj0 + one - 1) >>> FRAC_BITS : maj0 >>> FRAC_BITS;
        m    = min0 * up;
        base = m;
        hit_len = 0; col = 0; row = 0;
        m += ((line * one - maj0) * slope) / one;
        for (int k = 0; k < WALK_STEPS; k++) begin
            dmaj = line * one - maj0;
            dmin = m - base;
            if (dmaj < 0) dmaj = -dmaj;
            if (dmin < 0) dmin = -dmin;
            dmin = dmin >>> (QSH - FRAC_BITS);
            if (dmin > (64'sd1 << 31)) dmin = 64'sd1 << 31;
            d = root_floor(longint'(dmaj * dmaj) + longint'(dmin * dmin));
            if (d >= range_limit) return 1'b0;
            cm = dir > 0 ? line : line - 1;
            if (cm < 0 || cm >= MAP_SIDE || m < 0) return 1'b0;
            cn = m >>> QSH;
            if (cn >= MAP_SIDE) return 1'b0;
            col = vert ? int'(cm) : int'(cn);
            row = vert ? int'(cn) : int'(cm);
            if (solid_map[row * MAP_SIDE + col]) begin
                hit_len = d;
                return 1'b1;
            end
            line += dir;
            m += dir > 0 ? slope : -slope;
        end
        return 1'b0;
    endfunction

    function automatic t_wall_hit cast_ray(logic [POS_BITS-1:0] px, logic [POS_BITS-1:0] py,
                                           logic [ANG_BITS-1:0] az);
        longint cx, sy;
        longint unsigned hd, vd;
        int hc, hr, vc, vr;
        logic hok, vok;
        t_wall_hit r;
        hok = 0; vok = 0; hd = 0; vd = 0; hc = 0; hr = 0; vc = 0; vr = 0;
        ray_dir(az, cx, sy);
        if (sy != 0)
            hok = trace_half(longint'(py), longint'(px), (cx * (64'sd1 << QSH)) / sy,
                             sy > 0 ? 1 : -1, 1'b0, hd, hc, hr);
        if (cx != 0)
            vok = trace_half(longint'(px), longint'(py), (sy * (64'sd1 << QSH)) / cx,
                             cx > 0 ? 1 : -1, 1'b1, vd, vc, vr);
        r = '0;
        if (hok && (!vok || hd <= vd)) begin
            r.hit = 1; r.side = 0; r.col = hc[5:0]; r.row = hr[5:0];
            r.len = hd > 131071 ? 17'h1FFFF : hd[16:0];
        end else if (vok) begin
            r.hit = 1; r.side = 1; r.col = vc[5:0]; r.row = vr[5:0];
            r.len = vd > 131071 ? 17'h1FFFF : vd[16:0];
        end
        return r;
    endfunction

    t_wall_hit got, want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (solid_map[i]) solid_map[i] <= 1'b0;
            range_limit <= MAX_DIST_RESET;
            hits_due.delete();
            fails <= 0;
            due_cnt <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_MAX_DIST)
                range_limit <= pwdata[DIST_BITS-1:0];
            if (i_valid && i_ready_in) begin
                if (i_kind == KIND_WRITE)
                    solid_map[{i_cell_row, i_cell_col}] <= i_cell_solid;
                else
                    hits_due.push_back(cast_ray(i_pos_x, i_pos_y, i_azimuth));
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_hit, i_side, i_hit_col, i_hit_row, i_distance};
                if (hits_due.size() == 0) begin
                    if (fails < 10) $display("unexpected result word %p", got);
                    fails <= fails + 1;
                end else begin
                    want = hits_due.pop_front();
                    if (got !== want) begin
                        if (fails < 10) $display("expected %p got %p", want, got);
                        fails <= fails + 1;
                    end
                end
            end
            due_cnt <= hits_due.size();
        end
    end

    assign o_fails   = fails + due_cnt;
    assign o_pending = due_cnt;

endmodule

/* verif/grid_ray_wall_caster_core_test.sv */
module grid_ray_wall_caster_core_test import grc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_MAX_DIST = 3'd0;
    localparam int         PHASE_ITEMS  = 235;
    localparam int         STALL_LIMIT  = 40000;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 psel = 0, penable = 0, pwrite = 0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_valid = 0;
    logic                 o_ready;
    logic                 i_kind = 0;
    logic [MAP_BITS-1:0]  i_cell_col = '0, i_cell_row = '0;
    logic                 i_cell_solid = 0;
    logic [POS_BITS-1:0]  i_pos_x = '0, i_pos_y = '0;
    logic [ANG_BITS-1:0]  i_azimuth = '0;
    logic                 o_valid;
    logic                 i_ready = 0;
    logic                 o_hit, o_side;
    logic [MAP_BITS-1:0]  o_hit_col, o_hit_row;
    logic [DIST_BITS-1:0] o_distance;

    int fails, pending, quiet;
    bit calm = 0, hold_req = 0;

    always #5 i_clk = ~i_clk;

    grid_ray_wall_caster_core dut (.*);

    grid_ray_wall_caster_checker chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_valid, .i_ready_in(o_ready), .i_kind, .i_cell_col, .i_cell_row,
        .i_cell_solid, .i_pos_x, .i_pos_y, .i_azimuth,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_hit(o_hit), .i_side(o_side),
        .i_hit_col(o_hit_col), .i_hit_row(o_hit_row), .i_distance(o_distance),
        .o_fails(fails), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : receiver
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_ready <= 0;
                repeat (3000) @(posedge i_clk);
                hold_req = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 0;
                n = $urandom_range(1, 11);
                repeat (n) @(posedge i_clk);
            end else begin
                i_ready <= 1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic offer(logic kind, logic [5:0] col, logic [5:0] row, logic solid,
                         logic [15:0] px, logic [15:0] py, logic [11:0] az);
        logic rdy;
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 0;
            n = $urandom_range(1, 11);
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind <= kind; i_cell_col <= col; i_cell_row <= row; i_cell_solid <= solid;
        i_pos_x <= px; i_pos_y <= py; i_azimuth <= az;
        do begin
            @(negedge i_clk);
            rdy = o_ready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    task automatic put_cell(logic [5:0] col, logic [5:0] row, logic solid);
        offer(KIND_WRITE, col, row, solid, 16'($urandom), 16'($urandom), 12'($urandom));
    endtask

    task automatic shoot(logic [15:0] px, logic [15:0] py, logic [11:0] az);
        offer(KIND_CAST, 6'($urandom), 6'($urandom), 1'($urandom), px, py, az);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic set_range(logic [16:0] v);
        drain();
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_MAX_DIST; pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [11:0] pick_az();
        logic [11:0] a;
        a = 12'($urandom);
        if ($urandom_range(0, 9) == 0) a = {a[11:10], 10'd0};
        else if ($urandom_range(0, 19) == 0)
            a = {a[11:10], 10'd0} + 12'($urandom_range(0, 2)) - 12'd1;
        return a;
    endfunction

    task automatic random_run(int items, int wall_pct, bit local_view);
        logic [15:0] px, py;
        for (int i = 0; i < items; i++) begin
            if (!calm && i == items / 2 && hold_req == 0 && $urandom_range(0, 1) == 0)
                hold_req = 1;
            if ($urandom_range(0, 99) < wall_pct) begin
                put_cell(6'($urandom), 6'($urandom), $urandom_range(0, 3) != 0);
            end else begin
                px = 16'($urandom);
                py = 16'($urandom);
                if (local_view) begin
                    px = {6'($urandom_range(20, 43)), px[9:0]};
                    py = {6'($urandom_range(20, 43)), py[9:0]};
                end
                shoot(px, py, pick_az());
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        set_range(17'h1FFFF);
        put_cell(6'd0, 6'd0, 1);
        put_cell(6'd63, 6'd63, 1);
        put_cell(6'd40, 6'd32, 1);
        put_cell(6'd32, 6'd40, 1);
        put_cell(6'd20, 6'd32, 1);
        put_cell(6'd32, 6'd20, 1);
        for (int a = 0; a < 4; a++) shoot(16'h8200, 16'h8200, 12'(a * 1024));
        shoot(16'h8200, 16'h8200, 12'd1);
        shoot(16'h8200, 16'h8200, 12'd4095);
        shoot(16'h8200, 16'h8200, 12'd1023);
        shoot(16'h8200, 16'h8200, 12'd512);
        shoot(16'd0, 16'd0, 12'd512);
        shoot(16'hFFFF, 16'hFFFF, 12'd2560);
        shoot(16'hFFFF, 16'd0, 12'd1536);
        put_cell(6'd63, 6'd63, 0);
        shoot(16'hFFFF, 16'hFFFF, 12'd2560);
        set_range(17'd0);
        shoot(16'h8200, 16'h8200, 12'd0);
        shoot(16'h8200, 16'h8200, 12'd777);

        set_range(17'd4096);
        random_run(PHASE_ITEMS, 45, 1);
        set_range(17'h1FFFF);
        for (int k = 0; k < 64; k++) begin
            put_cell(6'(k), 6'd0, 1);
            put_cell(6'(k), 6'd63, 1);
            put_cell(6'd0, 6'(k), 1);
            put_cell(6'd63, 6'(k), 1);
        end
        random_run(PHASE_ITEMS, 20, 0);
        hold_req = 1;
        random_run(PHASE_ITEMS, 25, 1);
        set_range(17'($urandom_range(1, 131070)));
        random_run(PHASE_ITEMS, 30, 0);
        drain();
        set_range(MAX_DIST_RESET);
        calm = 1;
        random_run(140, 30, 1);

        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
